/* design/word_framer_heartbeat_pad_core_defines.svh */
// ---------------------------------------------------------------------------
// word framer assertion macros
// concurrent assertion wrappers used by the framer core
// ---------------------------------------------------------------------------
`ifndef WORD_FRAMER_HEARTBEAT_PAD_CORE_DEFINES_SVH
`define WORD_FRAMER_HEARTBEAT_PAD_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only while out of reset
`define WFHP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// checked on every edge, reset included
`define WFHP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define WFHP_ASSERT(lbl, prop, msg)
`define WFHP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* design/wfhp_pkg.sv */
// ---------------------------------------------------------------------------
// word framer package
// widths, register codes, microcode format and control store
// ---------------------------------------------------------------------------
package wfhp_pkg;

    localparam int DEF_WORDS_PER_FRAME = 16;
    localparam int DEF_MAX_BLOCK_WORDS = 128;

    localparam int CODE_W     = 8;
    localparam int PAYLOAD_W  = 24;
    localparam int TIME_W     = 48;
    localparam int WORD_W     = CODE_W + PAYLOAD_W;
    localparam int S_TDATA_W  = CODE_W + PAYLOAD_W + TIME_W;
    localparam int CNT_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = TIME_W;

    localparam logic [TIME_W-1:0] RST_HB_INTERVAL   = TIME_W'(1000);
    localparam logic [CODE_W-1:0] RST_NOP_CODE      = CODE_W'(0);
    localparam logic [CODE_W-1:0] RST_TIME_CODE_LOW = CODE_W'(1);
    localparam logic [CODE_W-1:0] RST_TIME_CODE_MID = CODE_W'(2);
    localparam logic [CODE_W-1:0] RST_TIME_CODE_HI  = CODE_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HB_INTERVAL,
        REG_NOP_CODE,
        REG_TIME_CODE_LOW,
        REG_TIME_CODE_MID,
        REG_TIME_CODE_HIGH
    } cfg_reg_t;

    // what the step puts into the output register
    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_TLOW,
        SRC_TMID,
        SRC_THIGH,
        SRC_DATA,
        SRC_NOP,
        SRC_MARK
    } word_src_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NOT_FULL,
        COND_NOP_AGAIN,
        COND_PAD_LEFT,
        COND_DISPATCH
    } cond_t;

    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t ADDR_FETCH      = upc_t'(0);
    localparam upc_t ADDR_HB_LOW     = upc_t'(1);
    localparam upc_t ADDR_HB_LOW_MK  = upc_t'(2);
    localparam upc_t ADDR_HB_MID     = upc_t'(3);
    localparam upc_t ADDR_HB_MID_MK  = upc_t'(4);
    localparam upc_t ADDR_HB_HIGH    = upc_t'(5);
    localparam upc_t ADDR_HB_HIGH_MK = upc_t'(6);
    localparam upc_t ADDR_DATA       = upc_t'(7);
    localparam upc_t ADDR_DATA_MK    = upc_t'(8);
    localparam upc_t ADDR_PAD        = upc_t'(9);
    localparam upc_t ADDR_PAD_MK     = upc_t'(10);
    localparam upc_t ADDR_LAST       = ADDR_PAD_MK;

    typedef struct packed {
        word_src_t src;
        cond_t     cond;
        upc_t      tgt_t;
        upc_t      tgt_f;
    } uword_t;

    typedef struct packed {
        logic is_flush;
        logic empty;
        logic pad_zero;
        logic hb_due;
        logic full;
        logic nop_again;
        logic pad_left;
    } useq_status_t;

    function automatic uword_t ucode_rom(upc_t addr);
        uword_t w;
        case (addr)
            ADDR_FETCH:      w = '{SRC_NONE,  COND_DISPATCH,  ADDR_FETCH,   ADDR_FETCH};
            ADDR_HB_LOW:     w = '{SRC_TLOW,  COND_NOT_FULL,  ADDR_HB_MID,  ADDR_HB_LOW_MK};
            ADDR_HB_LOW_MK:  w = '{SRC_MARK,  COND_ALWAYS,    ADDR_HB_MID,  ADDR_HB_MID};
            ADDR_HB_MID:     w = '{SRC_TMID,  COND_NOT_FULL,  ADDR_HB_HIGH, ADDR_HB_MID_MK};
            ADDR_HB_MID_MK:  w = '{SRC_MARK,  COND_ALWAYS,    ADDR_HB_HIGH, ADDR_HB_HIGH};
            ADDR_HB_HIGH:    w = '{SRC_THIGH, COND_NOT_FULL,  ADDR_DATA,    ADDR_HB_HIGH_MK};
            ADDR_HB_HIGH_MK: w = '{SRC_MARK,  COND_ALWAYS,    ADDR_DATA,    ADDR_DATA};
            ADDR_DATA:       w = '{SRC_DATA,  COND_NOT_FULL,  ADDR_FETCH,   ADDR_DATA_MK};
            ADDR_DATA_MK:    w = '{SRC_MARK,  COND_ALWAYS,    ADDR_FETCH,   ADDR_FETCH};
            ADDR_PAD:        w = '{SRC_NOP,   COND_NOP_AGAIN, ADDR_PAD,     ADDR_PAD_MK};
            // one marker always follows the pad loop exit: either block full or flush end
            ADDR_PAD_MK:     w = '{SRC_MARK,  COND_PAD_LEFT,  ADDR_PAD,     ADDR_FETCH};
            default:         w = '{SRC_NONE,  COND_ALWAYS,    ADDR_FETCH,   ADDR_FETCH};
        endcase
        return w;
    endfunction

endpackage

/* design/wfhp_useq.sv */
// ---------------------------------------------------------------------------
// word framer microsequencer
// step counter over the control store with two-way branches and dispatch
// ---------------------------------------------------------------------------
module wfhp_useq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_go,
    input  wfhp_pkg::useq_status_t status,
    output wfhp_pkg::uword_t       uword,
    output wfhp_pkg::upc_t         upc
);
    import wfhp_pkg::*;

    upc_t upc_reg;
    upc_t upc_next;
    logic take;

    assign uword = ucode_rom(upc_reg);
    assign upc   = upc_reg;

    always_comb begin
        case (uword.cond)
            COND_ALWAYS:    take = 1'b1;
            COND_NOT_FULL:  take = !status.full;
            COND_NOP_AGAIN: take = status.nop_again;
            COND_PAD_LEFT:  take = status.pad_left;
            default:        take = 1'b0;
        endcase
    end

    always_comb begin
        upc_next = upc_reg;
        if (step_go) begin
            if (uword.cond == COND_DISPATCH) begin
                if (status.is_flush) begin
                    if (status.empty) begin
                        upc_next = ADDR_FETCH;
                    end else if (status.pad_zero) begin
                        upc_next = ADDR_PAD_MK;
                    end else begin
                        upc_next = ADDR_PAD;
                    end
                end else if (status.hb_due) begin
                    upc_next = ADDR_HB_LOW;
                end else begin
                    upc_next = ADDR_DATA;
                end
            end else begin
                upc_next = take ? uword.tgt_t : uword.tgt_f;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= ADDR_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

/* design/word_framer_heartbeat_pad_core.sv */
// ---------------------------------------------------------------------------
// word framer with heartbeat and block padding
// packs items into 32-bit words, inserts time heartbeats, frames blocks
// ---------------------------------------------------------------------------
// A microcoded sequencer runs one control step per clock and a step that
// emits a word waits until the output register is free. Each item is taken
// in at the fetch step, then each result word has a step of its own: a data
// item gives one word, or four when a three-word heartbeat goes ahead of it,
// plus a block-end marker for each block that fills. A flush gives one NOP
// pad word per free position left in the frame (up to WORDS_PER_FRAME-1)
// plus its block-end markers; a flush of an empty block gives no word. s_tready
// is high only while the sequencer sits at its fetch step. Block-end markers
// come out with m_tlast high and m_tdata zero.
`include "word_framer_heartbeat_pad_core_defines.svh"

module word_framer_heartbeat_pad_core #(
    parameter int WORDS_PER_FRAME = wfhp_pkg::DEF_WORDS_PER_FRAME,
    parameter int MAX_BLOCK_WORDS = wfhp_pkg::DEF_MAX_BLOCK_WORDS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // ep_code [7:0], payload [31:8], event_time [79:32]
    input  logic [wfhp_pkg::S_TDATA_W-1:0]   s_tdata,
    // is_flush
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_word [31:0]
    output logic [wfhp_pkg::WORD_W-1:0]      m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [wfhp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wfhp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import wfhp_pkg::*;

    localparam int PosW = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1;
    localparam logic [PosW-1:0]  PosLast = PosW'(WORDS_PER_FRAME - 1);
    localparam logic [CNT_W-1:0] CntMax  = CNT_W'(MAX_BLOCK_WORDS);

    // configuration
    logic [TIME_W-1:0] hb_interval_reg;
    logic [CODE_W-1:0] nop_code_reg;
    logic [CODE_W-1:0] tcode_low_reg;
    logic [CODE_W-1:0] tcode_mid_reg;
    logic [CODE_W-1:0] tcode_high_reg;

    // state and datapath
    logic [TIME_W-1:0]    last_hb_reg,  last_hb_next;
    logic [CNT_W-1:0]     wib_reg,      wib_next;
    logic [PosW-1:0]      pos_reg,      pos_next;
    logic [PosW-1:0]      pad_reg,      pad_next;
    logic [CODE_W-1:0]    ep_reg,       ep_next;
    logic [PAYLOAD_W-1:0] payload_reg,  payload_next;
    logic [TIME_W-1:0]    time_reg,     time_next;
    logic [WORD_W-1:0]    out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    logic [CODE_W-1:0]    in_ep;
    logic [PAYLOAD_W-1:0] in_payload;
    logic [TIME_W-1:0]    in_time;
    logic [TIME_W-1:0]    time_diff;
    logic                 hb_due;
    logic [CNT_W-1:0]     wib_inc;
    logic [PosW-1:0]      pos_inc;
    logic [PosW-1:0]      pad_init;
    logic [WORD_W-1:0]    word_sel;
    logic                 out_free;
    logic                 step_go;

    uword_t       uword;
    upc_t         upc;
    useq_status_t status;

    assign in_ep      = s_tdata[CODE_W-1:0];
    assign in_payload = s_tdata[CODE_W+PAYLOAD_W-1:CODE_W];
    assign in_time    = s_tdata[S_TDATA_W-1:CODE_W+PAYLOAD_W];

    assign time_diff = in_time - last_hb_reg;
    assign hb_due    = time_diff >= hb_interval_reg;

    assign wib_inc  = wib_reg + CNT_W'(1);
    assign pos_inc  = (pos_reg == PosLast) ? '0 : pos_reg + PosW'(1);
    assign pad_init = (pos_reg == '0) ? '0 : PosW'(WORDS_PER_FRAME - int'(pos_reg));

    assign status.is_flush  = s_tuser;
    assign status.empty     = (wib_reg == '0);
    assign status.pad_zero  = (pos_reg == '0);
    assign status.hb_due    = hb_due;
    assign status.full      = (wib_inc == CntMax);
    assign status.nop_again = (wib_inc != CntMax) && (pad_reg != PosW'(1));
    assign status.pad_left  = (pad_reg != '0);

    assign out_free = !m_tvalid_reg || m_tready;
    assign step_go  = (uword.src == SRC_NONE) ? s_tvalid : out_free;

    assign s_tready = (upc == ADDR_FETCH);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    wfhp_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_go (step_go),
        .status  (status),
        .uword   (uword),
        .upc     (upc)
    );

    always_comb begin
        case (uword.src)
            SRC_TLOW:  word_sel = {tcode_low_reg, time_reg[PAYLOAD_W-1:0]};
            SRC_TMID:  word_sel = {tcode_mid_reg, time_reg[TIME_W-1:PAYLOAD_W]};
            SRC_THIGH: word_sel = {tcode_high_reg, {PAYLOAD_W{1'b0}}};
            SRC_DATA:  word_sel = {ep_reg, payload_reg};
            SRC_NOP:   word_sel = {nop_code_reg, {PAYLOAD_W{1'b0}}};
            default:   word_sel = '0;
        endcase
    end

    always_comb begin
        last_hb_next  = last_hb_reg;
        wib_next      = wib_reg;
        pos_next      = pos_reg;
        pad_next      = pad_reg;
        ep_next       = ep_reg;
        payload_next  = payload_reg;
        time_next     = time_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (step_go) begin
            if (uword.src == SRC_NONE) begin
                // input transaction taken
                ep_next      = in_ep;
                payload_next = in_payload;
                time_next    = in_time;
                pad_next     = pad_init;
                if (!s_tuser && hb_due) begin
                    last_hb_next = in_time;
                end
            end else if (uword.src == SRC_MARK) begin
                out_data_next = '0;
                out_last_next = 1'b1;
                m_tvalid_next = 1'b1;
                wib_next      = '0;
                pos_next      = '0;
            end else begin
                out_data_next = word_sel;
                out_last_next = 1'b0;
                m_tvalid_next = 1'b1;
                // held at the maximum until the marker step clears it
                wib_next      = wib_inc;
                pos_next      = pos_inc;
                if (uword.src == SRC_NOP) begin
                    pad_next = pad_reg - PosW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_hb_reg  <= '0;
            wib_reg      <= '0;
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            last_hb_reg  <= last_hb_next;
            wib_reg      <= wib_next;
            pos_reg      <= pos_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pad_reg      <= pad_next;
        ep_reg       <= ep_next;
        payload_reg  <= payload_next;
        time_reg     <= time_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hb_interval_reg <= RST_HB_INTERVAL;
            nop_code_reg    <= RST_NOP_CODE;
            tcode_low_reg   <= RST_TIME_CODE_LOW;
            tcode_mid_reg   <= RST_TIME_CODE_MID;
            tcode_high_reg  <= RST_TIME_CODE_HI;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_HB_INTERVAL:    hb_interval_reg <= cfg_wdata;
                REG_NOP_CODE:       nop_code_reg    <= cfg_wdata[CODE_W-1:0];
                REG_TIME_CODE_LOW:  tcode_low_reg   <= cfg_wdata[CODE_W-1:0];
                REG_TIME_CODE_MID:  tcode_mid_reg   <= cfg_wdata[CODE_W-1:0];
                REG_TIME_CODE_HIGH: tcode_high_reg  <= cfg_wdata[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    `WFHP_ASSERT_RST(a_reset_clears, !aresetn |=> (wib_reg == '0) && (pos_reg == '0) && !m_tvalid_reg, "reset did not clear block state")
    `WFHP_ASSERT(a_block_bound, wib_reg <= CntMax, "block word count past maximum")
    `WFHP_ASSERT(a_frame_bound, int'(pos_reg) < WORDS_PER_FRAME, "frame position out of range")
    `WFHP_ASSERT(a_marker_zero, m_tvalid && m_tlast |-> m_tdata == '0, "block-end marker carries data")
    `WFHP_ASSERT(a_upc_bound, upc <= ADDR_LAST, "sequencer left its program")

endmodule

/* test/word_framer_heartbeat_pad_check.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// word framer result checker
// follows config writes and input transactions, predicts the framed word
// stream and compares every result transaction with the oldest prediction
// ---------------------------------------------------------------------------
module word_framer_heartbeat_pad_check #(
    parameter int WORDS_PER_FRAME = wfhp_pkg::DEF_WORDS_PER_FRAME,
    parameter int MAX_BLOCK_WORDS = wfhp_pkg::DEF_MAX_BLOCK_WORDS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [wfhp_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [wfhp_pkg::WORD_W-1:0]      m_tdata,
    input  logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [wfhp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wfhp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                               mismatch_count,
    output int                               words_outstanding
);
    import wfhp_pkg::*;

    localparam int EXP_DEPTH = 256;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              mark;
    } framed_t;

    // circular store of predicted result transactions, oldest at the read pointer
    framed_t    expected_words [EXP_DEPTH];
    logic [7:0] exp_rd_ptr;
    logic [7:0] exp_wr_ptr;
    int         exp_count = 0;
    int         fails = 0;

    logic [TIME_W-1:0] beat_interval;
    logic [CODE_W-1:0] pad_code;
    logic [CODE_W-1:0] code_tlow;
    logic [CODE_W-1:0] code_tmid;
    logic [CODE_W-1:0] code_thigh;
    logic [TIME_W-1:0] last_beat;
    logic [CNT_W-1:0]  block_fill;

    function automatic void add_expected(input framed_t f);
        expected_words[exp_wr_ptr] = f;
        exp_wr_ptr = exp_wr_ptr + 8'd1;
        exp_count++;
    endfunction

    function automatic framed_t take_expected();
        framed_t f;
        f = expected_words[exp_rd_ptr];
        exp_rd_ptr = exp_rd_ptr + 8'd1;
        exp_count--;
        return f;
    endfunction

    function automatic void close_block();
        add_expected('{word: '0, mark: 1'b1});
        block_fill = '0;
    endfunction

    function automatic void push_word(input logic [WORD_W-1:0] w);
        add_expected('{word: w, mark: 1'b0});
        block_fill = block_fill + CNT_W'(1);
        if (int'(block_fill) >= MAX_BLOCK_WORDS) close_block();
    endfunction

    function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_HB_INTERVAL:    beat_interval = val[TIME_W-1:0];
            REG_NOP_CODE:       pad_code      = val[CODE_W-1:0];
            REG_TIME_CODE_LOW:  code_tlow     = val[CODE_W-1:0];
            REG_TIME_CODE_MID:  code_tmid     = val[CODE_W-1:0];
            REG_TIME_CODE_HIGH: code_thigh    = val[CODE_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void frame_item(input logic flush,
                                       input logic [S_TDATA_W-1:0] data);
        logic [CODE_W-1:0]    code;
        logic [PAYLOAD_W-1:0] pay;
        logic [TIME_W-1:0]    stamp;
        logic [TIME_W-1:0]    age;
        int                   pad;
        code  = data[CODE_W-1:0];
        pay   = data[WORD_W-1:CODE_W];
        stamp = data[S_TDATA_W-1:WORD_W];
        if (flush) begin
            if (block_fill != 0) begin
                pad = (WORDS_PER_FRAME - (int'(block_fill) % WORDS_PER_FRAME))
                      % WORDS_PER_FRAME;
                repeat (pad) push_word({pad_code, PAYLOAD_W'(0)});
                // padding may already have closed the block
                if (block_fill != 0) close_block();
            end
        end else begin
            age = stamp - last_beat;
            if (age >= beat_interval) begin
                last_beat = stamp;
                push_word({code_tlow, stamp[PAYLOAD_W-1:0]});
                push_word({code_tmid, stamp[TIME_W-1:PAYLOAD_W]});
                push_word({code_thigh, PAYLOAD_W'(0)});
            end
            push_word({code, pay});
        end
    endfunction

    always @(posedge aclk) begin : watch
        framed_t want;
        if (!aresetn) begin
            beat_interval = RST_HB_INTERVAL;
            pad_code      = RST_NOP_CODE;
            code_tlow     = RST_TIME_CODE_LOW;
            code_tmid     = RST_TIME_CODE_MID;
            code_thigh    = RST_TIME_CODE_HI;
            last_beat     = '0;
            block_fill    = '0;
            exp_rd_ptr    = '0;
            exp_wr_ptr    = '0;
            exp_count     = 0;
        end else begin
            if (cfg_we) apply_write(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready) frame_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (exp_count == 0) begin
                    fails++;
                    $display("%0t: unexpected result transaction, word %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = take_expected();
                    if (m_tdata !== want.word) begin
                        fails++;
                        $display("%0t: word mismatch, expected %h, actual %h",
                                 $time, want.word, m_tdata);
                    end
                    if (m_tlast !== want.mark) begin
                        fails++;
                        $display("%0t: block end mismatch, expected %b, actual %b",
                                 $time, want.mark, m_tlast);
                    end
                end
            end
        end
        mismatch_count    <= fails;
        words_outstanding <= exp_count;
    end

endmodule

/* test/word_framer_heartbeat_pad_core_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// word framer testbench
// directed and random items over several register settings, random idling
// on both channels and one long receiver hold-off; checking in the checker
// ---------------------------------------------------------------------------
module word_framer_heartbeat_pad_core_test;
    import wfhp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 20;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [WORD_W-1:0]     m_tdata;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    mismatch_count;
    int                    words_outstanding;

    logic [TIME_W-1:0] now_stamp;
    bit                tx_steady;
    bit                no_gaps;
    bit                hold_off_req;

    word_framer_heartbeat_pad_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    word_framer_heartbeat_pad_check i_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .mismatch_count    (mismatch_count),
        .words_outstanding (words_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // receiver: stretches of steady acceptance and of random stalls
    initial begin : rx_side
        int  rest;
        int  stretch;
        bit  steady;
        rest    = 0;
        stretch = 0;
        steady  = 1'b0;
        m_tready <= 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if (rest > 0) begin
                m_tready <= 1'b0;
                rest--;
            end else begin
                m_tready <= 1'b1;
                if (stretch == 0) begin
                    steady  = ($urandom_range(0, 2) == 0);
                    stretch = $urandom_range(20, 150);
                end else begin
                    stretch--;
                end
                if (!steady && $urandom_range(0, 3) == 0) rest = idle_len();
            end
        end
    end

    task automatic offer(input logic flush, input logic [CODE_W-1:0] code,
                         input logic [PAYLOAD_W-1:0] pay, input logic [TIME_W-1:0] stamp);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= flush;
        s_tdata  <= {stamp, pay, code};
        do @(posedge aclk); while (!s_tready);
        gap = (tx_steady || no_gaps || $urandom_range(0, 2) != 0) ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic offer_data(input logic [CODE_W-1:0] code, input logic [PAYLOAD_W-1:0] pay,
                              input logic [TIME_W-1:0] stamp);
        now_stamp = stamp;
        offer(1'b0, code, pay, stamp);
    endtask

    // other fields of a flush are don't-care, so they carry noise
    task automatic offer_flush();
        offer(1'b1, CODE_W'($urandom), PAYLOAD_W'($urandom),
              TIME_W'({$urandom, $urandom}));
    endtask

    // flush_one_in of 0 means data items only
    task automatic offer_random(input int flush_one_in, input int step_max);
        logic [TIME_W-1:0] stamp;
        if ($urandom_range(0, 39) == 0) tx_steady = ~tx_steady;
        if (flush_one_in > 0 && $urandom_range(0, flush_one_in - 1) == 0) begin
            offer_flush();
        end else begin
            if (flush_one_in > 0 && $urandom_range(0, 19) == 0)
                stamp = TIME_W'({$urandom, $urandom});
            else
                stamp = now_stamp + TIME_W'($urandom_range(0, step_max));
            offer_data(CODE_W'($urandom), PAYLOAD_W'($urandom), stamp);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // wait for the block to drain before touching the registers
    task automatic settle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (words_outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        now_stamp    = '0;
        tx_steady    = 1'b0;
        no_gaps      = 1'b0;
        hold_off_req = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: boundaries of the heartbeat interval and of the fields
        offer_flush();                                  // empty block, no output
        offer_data(8'hFF, 24'hFF_FFFF, 48'd0);
        offer_data(8'h00, 24'h00_0000, 48'd999);
        offer_data(8'hA5, 24'h5A_5A5A, 48'd1000);       // exactly one interval
        offer_data(8'h5A, 24'hA5_A5A5, 48'hFFFF_FFFF_FFFF);
        offer_data(8'h3C, 24'h12_3456, 48'h8000_0000_0000); // time going backwards
        offer_data(8'hC3, 24'h65_4321, 48'd5);
        offer_flush();
        offer_flush();
        offer_data(8'h11, 24'h00_0001, 48'd1004);       // one short of the interval
        offer_data(8'h22, 24'h80_0000, 48'd1005);
        offer_flush();
        offer_data(8'h80, 24'h00_FFFF, 48'd1100);
        settle();

        // zero interval: every data item carries a heartbeat
        write_reg(REG_HB_INTERVAL, '0);
        write_reg(REG_NOP_CODE, CFG_DATA_W'(8'hFF));
        write_reg(REG_TIME_CODE_LOW, CFG_DATA_W'(8'hFF));
        write_reg(REG_TIME_CODE_MID, CFG_DATA_W'(8'hFF));
        write_reg(REG_TIME_CODE_HIGH, CFG_DATA_W'(8'hFF));
        write_reg(REG_UNUSED, '1);
        cfg_we <= 1'b0;
        for (int i = 0; i < 100; i++) offer_random(20, 5000);
        settle();

        // widest interval: only a step of all ones minus nothing reaches it
        write_reg(REG_HB_INTERVAL, CFG_DATA_W'(48'hFFFF_FFFF_FFFF));
        write_reg(REG_NOP_CODE, CFG_DATA_W'($urandom_range(0, 255)));
        write_reg(REG_TIME_CODE_LOW, '0);
        write_reg(REG_TIME_CODE_MID, '0);
        write_reg(REG_TIME_CODE_HIGH, '0);
        cfg_we <= 1'b0;
        offer_data(CODE_W'($urandom), PAYLOAD_W'($urandom), now_stamp - 1'b1);
        offer_flush();
        // block of 118 words: the flush padding then fills it exactly
        for (int i = 0; i < 118; i++) offer_random(0, 300);
        offer_flush();
        for (int i = 0; i < 20; i++) offer_random(10, 300);
        settle();

        // mid-range interval with random codes
        write_reg(REG_HB_INTERVAL, CFG_DATA_W'($urandom_range(1, 3000)));
        write_reg(REG_NOP_CODE, CFG_DATA_W'($urandom_range(0, 255)));
        write_reg(REG_TIME_CODE_LOW, CFG_DATA_W'($urandom_range(0, 255)));
        write_reg(REG_TIME_CODE_MID, CFG_DATA_W'($urandom_range(0, 255)));
        write_reg(REG_TIME_CODE_HIGH, CFG_DATA_W'($urandom_range(0, 255)));
        cfg_we <= 1'b0;
        for (int i = 0; i < 100; i++) offer_random(50, 400);
        // receiver holds off while items keep coming back to back
        hold_off_req = 1'b1;
        no_gaps      = 1'b1;
        for (int i = 0; i < 30; i++) offer_random(50, 400);
        no_gaps      = 1'b0;
        for (int i = 0; i < 110; i++) offer_random(50, 400);
        settle();

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* word_framer_heartbeat_pad_core.f */
+incdir+design
design/wfhp_pkg.sv
design/wfhp_useq.sv
design/word_framer_heartbeat_pad_core.sv
test/word_framer_heartbeat_pad_check.sv
test/word_framer_heartbeat_pad_core_test.sv
